### rtl/mqtt_rk_pkg.sv
// ----------------------------------------------------------------------------
// mqtt_rk_pkg
// Shared types and constants for the MQTT receiver with keepalive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mqtt_rk_pkg;

  // Input actions
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_SESSION = 2'd2;
  localparam logic [1:0] ACT_SENT    = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_TOPIC    = 3'd0;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd1;
  localparam logic [2:0] KIND_PUB_END  = 3'd2;
  localparam logic [2:0] KIND_PINGREQ  = 3'd3;
  localparam logic [2:0] KIND_PINGRESP = 3'd4;
  localparam logic [2:0] KIND_PUBACK   = 3'd5;
  localparam logic [2:0] KIND_PONG     = 3'd6;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd7;

  // Receive phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;
  localparam logic [1:0] PH_DISCARD = 2'd3;

  // Packet types (upper nibble of the fixed header)
  localparam logic [7:0] TYPE_MASK     = 8'hF0;
  localparam logic [7:0] TYPE_PUBLISH  = 8'h30;
  localparam logic [7:0] TYPE_PINGREQ  = 8'hC0;
  localparam logic [7:0] TYPE_PINGRESP = 8'hD0;

  // Configuration register indexes and reset values
  localparam logic [1:0]  CFG_KEEPALIVE = 2'd0;
  localparam logic [1:0]  CFG_BYTE_TMO  = 2'd1;
  localparam logic [1:0]  CFG_MAX_PKT   = 2'd2;
  localparam logic [25:0] KEEPALIVE_RST = 26'd15000;
  localparam logic [25:0] BYTE_TMO_RST  = 26'd15000;
  localparam logic [15:0] MAX_PKT_RST   = 16'd128;

  localparam int MAX_RES = 3;

  // One result item (last is derived at the output)
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] message_id;
    logic [15:0] topic_length;
    logic [15:0] payload_length;
    logic        accepted;
  } item_t;

  // All results caused by one input item
  typedef struct packed {
    item_t [MAX_RES-1:0] slot;
    logic [1:0]          cnt;
  } res_t;

  // Receiver and keepalive state
  typedef struct packed {
    logic [1:0]  rx_phase;
    logic [7:0]  header_byte;
    logic [15:0] remaining_length;
    logic [2:0]  length_byte_count;
    logic [15:0] body_count;
    logic [15:0] topic_len;
    logic [15:0] msg_id;
    logic [31:0] since_in_ms;
    logic [31:0] since_out_ms;
    logic [31:0] byte_gap_ms;
    logic        ping_pending;
    logic        live;
  } st_t;

  typedef struct packed {
    st_t  st;
    res_t res;
  } ctx_t;

endpackage

### rtl/mqtt_receive_and_keepalive.sv
// ----------------------------------------------------------------------------
// mqtt_receive_and_keepalive
// MQTT 3.1.1 client receive framer with keepalive timer.
// ----------------------------------------------------------------------------
// Input channel (in_*): one item per event. in_tuser carries the action
// (byte received, millisecond tick, session start, outbound packet sent),
// in_tdata the received byte. Result channel (out_*): topic and payload
// bytes, publish end, PINGREQ/PINGRESP/PUBACK requests, PINGRESP seen and
// keepalive timeout. tlast marks the final result of one input item.
// Config channel (cfg_*): register writes, always ready; write only while
// the block is idle.
// Results of an item are registered into set0 (set1 while set0 is busy).
// Throughput: one input item per cycle while each item gives at most one
// result and the receiver keeps up; an item giving more than one result
// occupies the output until the three-slot result register, drained one
// result per cycle, is empty. A second result register lets the next
// item be taken while results still wait, so a stalled receiver blocks
// the input only once both registers hold results.
// Reset: session down, receive state and timers cleared, config registers
// back to their defaults, no results pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_receive_and_keepalive (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] data_byte, [23:8] message_id,
                                  // [39:24] topic_length,
                                  // [55:40] payload_length, [56] accepted
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic mqtt_rk_pkg::res_t f_emit(mqtt_rk_pkg::res_t r,
                                               logic [2:0] kind,
                                               logic [7:0] data,
                                               logic [15:0] mid,
                                               logic [15:0] tl,
                                               logic [15:0] pl,
                                               logic acc);
    mqtt_rk_pkg::res_t o;
    o = r;
    if (r.cnt != 2'd3) begin
      o.slot[r.cnt] = '{kind: kind, data_byte: data, message_id: mid,
                        topic_length: tl, payload_length: pl, accepted: acc};
      o.cnt = r.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic logic [31:0] f_inc_sat(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // bytes a publish body needs before its payload: topic length field,
  // topic, and packet id when QoS is nonzero
  function automatic logic [17:0] f_need(mqtt_rk_pkg::st_t s);
    return 18'd2 + {2'b0, s.topic_len} +
           ((s.header_byte[2:1] != 2'd0) ? 18'd2 : 18'd0);
  endfunction

  function automatic mqtt_rk_pkg::st_t f_clear_rx(mqtt_rk_pkg::st_t s);
    mqtt_rk_pkg::st_t o;
    o = s;
    o.rx_phase          = mqtt_rk_pkg::PH_HEADER;
    o.header_byte       = '0;
    o.remaining_length  = '0;
    o.length_byte_count = '0;
    o.body_count        = '0;
    o.topic_len         = '0;
    o.msg_id            = '0;
    o.byte_gap_ms       = '0;
    return o;
  endfunction

  // end of a packet, good or dropped
  function automatic mqtt_rk_pkg::ctx_t f_finish(mqtt_rk_pkg::ctx_t c, logic ok);
    mqtt_rk_pkg::ctx_t o;
    logic [7:0]  ptype;
    logic [1:0]  q;
    logic [15:0] mid;
    logic [17:0] need;
    o     = c;
    ptype = c.st.header_byte & mqtt_rk_pkg::TYPE_MASK;
    q     = c.st.header_byte[2:1];
    mid   = (q != 2'd0) ? c.st.msg_id : 16'd0;
    need  = f_need(c.st);
    o.st.rx_phase    = mqtt_rk_pkg::PH_HEADER;
    o.st.byte_gap_ms = '0;
    if (!ok) begin
      if (ptype == mqtt_rk_pkg::TYPE_PUBLISH)
        o.res = f_emit(o.res, mqtt_rk_pkg::KIND_PUB_END, 8'd0, 16'd0, 16'd0,
                       16'd0, 1'b0);
    end else begin
      o.st.since_in_ms = '0;
      if (ptype == mqtt_rk_pkg::TYPE_PUBLISH) begin
        o.res = f_emit(o.res, mqtt_rk_pkg::KIND_PUB_END, 8'd0, mid,
                       c.st.topic_len, c.st.remaining_length - need[15:0], 1'b1);
        if (q == 2'd1) begin
          o.res = f_emit(o.res, mqtt_rk_pkg::KIND_PUBACK, 8'd0, mid, 16'd0,
                         16'd0, 1'b0);
          o.st.since_out_ms = '0;
        end
      end else if (ptype == mqtt_rk_pkg::TYPE_PINGREQ) begin
        o.res = f_emit(o.res, mqtt_rk_pkg::KIND_PINGRESP, 8'd0, 16'd0, 16'd0,
                       16'd0, 1'b0);
      end else if (ptype == mqtt_rk_pkg::TYPE_PINGRESP) begin
        o.st.ping_pending = 1'b0;
        o.res = f_emit(o.res, mqtt_rk_pkg::KIND_PONG, 8'd0, 16'd0, 16'd0,
                       16'd0, 1'b0);
      end
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [25:0]       keepalive_r, byte_tmo_r;
  logic [15:0]       max_pkt_r;
  mqtt_rk_pkg::st_t  st_r, st_nxt;
  mqtt_rk_pkg::res_t set0_r, set1_r, new_res;
  logic [1:0]        idx_r;

  logic accept, pop, pop_last, set0_free;

  // config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keepalive_r <= mqtt_rk_pkg::KEEPALIVE_RST;
      byte_tmo_r  <= mqtt_rk_pkg::BYTE_TMO_RST;
      max_pkt_r   <= mqtt_rk_pkg::MAX_PKT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mqtt_rk_pkg::CFG_KEEPALIVE: keepalive_r <= cfg_data;
        mqtt_rk_pkg::CFG_BYTE_TMO:  byte_tmo_r  <= cfg_data;
        mqtt_rk_pkg::CFG_MAX_PKT:   max_pkt_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Per-item decode: next state and results
  // --------------------------------------------------------------------------
  always_comb begin
    mqtt_rk_pkg::ctx_t c;
    logic [1:0]  lc;
    logic [28:0] sh, acc;
    logic [17:0] total;
    logic        bad;
    logic [16:0] idx, t2, t4, idx1;
    logic [7:0]  b;
    c.st  = st_r;
    c.res = '0;
    b     = in_tdata;
    lc    = '0;
    sh    = '0;
    acc   = '0;
    total = '0;
    bad   = 1'b0;
    idx   = '0;
    t2    = '0;
    t4    = '0;
    idx1  = '0;

    unique case (in_tuser)
      mqtt_rk_pkg::ACT_SESSION: begin
        c.st              = f_clear_rx(c.st);
        c.st.since_in_ms  = '0;
        c.st.since_out_ms = '0;
        c.st.ping_pending = 1'b0;
        c.st.live         = 1'b1;
      end
      mqtt_rk_pkg::ACT_SENT: begin
        c.st.since_out_ms = '0;
      end
      mqtt_rk_pkg::ACT_TICK: begin
        if (c.st.live) begin
          c.st.since_in_ms  = f_inc_sat(c.st.since_in_ms);
          c.st.since_out_ms = f_inc_sat(c.st.since_out_ms);
          // stalled packet
          if (c.st.rx_phase != mqtt_rk_pkg::PH_HEADER) begin
            c.st.byte_gap_ms = f_inc_sat(c.st.byte_gap_ms);
            if (c.st.byte_gap_ms >= {6'b0, byte_tmo_r}) c = f_finish(c, 1'b0);
          end
          // keepalive
          if (c.st.since_in_ms > {6'b0, keepalive_r} ||
              c.st.since_out_ms > {6'b0, keepalive_r}) begin
            if (c.st.ping_pending) begin
              c.res     = f_emit(c.res, mqtt_rk_pkg::KIND_TIMEOUT, 8'd0, 16'd0,
                                 16'd0, 16'd0, 1'b0);
              c.st.live = 1'b0;
              c.st      = f_clear_rx(c.st);
            end else begin
              c.res             = f_emit(c.res, mqtt_rk_pkg::KIND_PINGREQ, 8'd0,
                                         16'd0, 16'd0, 16'd0, 1'b0);
              c.st.since_in_ms  = '0;
              c.st.since_out_ms = '0;
              c.st.ping_pending = 1'b1;
            end
          end
        end
      end
      default: begin
        if (c.st.live) begin
          c.st.byte_gap_ms = '0;
          if (c.st.rx_phase == mqtt_rk_pkg::PH_HEADER) begin
            // fixed header byte
            c.st.header_byte       = b;
            c.st.remaining_length  = '0;
            c.st.length_byte_count = '0;
            c.st.body_count        = '0;
            c.st.topic_len         = '0;
            c.st.msg_id            = '0;
            c.st.rx_phase          = mqtt_rk_pkg::PH_LENGTH;
          end else if (c.st.rx_phase == mqtt_rk_pkg::PH_LENGTH) begin
            // remaining length, 7 bits per byte, saturating at 16 bits
            lc  = c.st.length_byte_count[1:0];
            sh  = {22'b0, b[6:0]} << ({3'b0, lc} * 5'd7);
            acc = {13'b0, c.st.remaining_length} + sh;
            c.st.remaining_length  = (acc > 29'h0FFFF) ? 16'hFFFF : acc[15:0];
            c.st.length_byte_count = {1'b0, lc} + 3'd1;
            if (b[7]) begin
              // continuation on the fourth length byte: abandon
              if (lc == 2'd3) c = f_finish(c, 1'b0);
            end else begin
              total = 18'd2 + {16'b0, lc} + {2'b0, c.st.remaining_length};
              bad   = (total > {2'b0, max_pkt_r}) ||
                      ((c.st.header_byte & mqtt_rk_pkg::TYPE_MASK) ==
                         mqtt_rk_pkg::TYPE_PUBLISH &&
                       c.st.remaining_length < 16'd2);
              c.st.body_count = '0;
              if (c.st.remaining_length == 16'd0) c = f_finish(c, !bad);
              else c.st.rx_phase = bad ? mqtt_rk_pkg::PH_DISCARD
                                       : mqtt_rk_pkg::PH_BODY;
            end
          end else begin
            // body byte
            idx = {1'b0, c.st.body_count};
            if (c.st.rx_phase == mqtt_rk_pkg::PH_BODY &&
                (c.st.header_byte & mqtt_rk_pkg::TYPE_MASK) ==
                  mqtt_rk_pkg::TYPE_PUBLISH) begin
              t2 = {1'b0, c.st.topic_len} + 17'd2;
              t4 = {1'b0, c.st.topic_len} + 17'd4;
              if (idx == 17'd0) begin
                c.st.topic_len = {b, 8'd0};
              end else if (idx == 17'd1) begin
                c.st.topic_len = {c.st.topic_len[15:8], b};
                if (c.st.header_byte[2:1] == 2'd3 ||
                    f_need(c.st) > {2'b0, c.st.remaining_length})
                  c.st.rx_phase = mqtt_rk_pkg::PH_DISCARD;
              end else if (idx < t2) begin
                c.res = f_emit(c.res, mqtt_rk_pkg::KIND_TOPIC, b, 16'd0, 16'd0,
                               16'd0, 1'b0);
              end else if (c.st.header_byte[2:1] != 2'd0 && idx < t4) begin
                if (idx == t2) c.st.msg_id = {b, 8'd0};
                else c.st.msg_id = {c.st.msg_id[15:8], b};
              end else begin
                c.res = f_emit(c.res, mqtt_rk_pkg::KIND_PAYLOAD, b, 16'd0,
                               16'd0, 16'd0, 1'b0);
              end
            end
            idx1 = idx + 17'd1;
            c.st.body_count = idx1[15:0];
            if (idx1 >= {1'b0, c.st.remaining_length})
              c = f_finish(c, c.st.rx_phase == mqtt_rk_pkg::PH_BODY);
          end
        end
      end
    endcase

    st_nxt  = c.st;
    new_res = c.res;
  end

  // --------------------------------------------------------------------------
  // Result registers: set0 drains to the port, set1 holds the next item's
  // results while set0 is still busy
  // --------------------------------------------------------------------------
  assign out_tvalid = (set0_r.cnt != 2'd0);
  assign out_tlast  = (idx_r == set0_r.cnt - 2'd1);
  assign pop        = out_tvalid && out_tready;
  assign pop_last   = pop && out_tlast;
  assign set0_free  = (set0_r.cnt == 2'd0) || pop_last;
  assign in_tready  = (set1_r.cnt == 2'd0);
  assign accept     = in_tvalid && in_tready;

  assign out_tuser = set0_r.slot[idx_r].kind;
  assign out_tdata = {7'd0,
                      set0_r.slot[idx_r].accepted,
                      set0_r.slot[idx_r].payload_length,
                      set0_r.slot[idx_r].topic_length,
                      set0_r.slot[idx_r].message_id,
                      set0_r.slot[idx_r].data_byte};

  // state update on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // result set handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set0_r.cnt <= '0;
      set1_r.cnt <= '0;
      idx_r      <= '0;
    end else begin
      if (accept && new_res.cnt != 2'd0) begin
        if (set0_free) begin
          set0_r <= new_res;
          idx_r  <= '0;
        end else begin
          set1_r <= new_res;
          if (pop) idx_r <= idx_r + 2'd1;
        end
      end else if (set0_free) begin
        idx_r <= '0;
        if (set1_r.cnt != 2'd0) begin
          set0_r     <= set1_r;
          set1_r.cnt <= '0;
        end else begin
          set0_r.cnt <= '0;
        end
      end else if (pop) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule
